[hdl/rccv_pkg.sv]
`timescale 1ns / 1ps

package rccv_pkg;

   // Widths fixed by the register map and the result fields.
   localparam int LIMIT_W    = 18;
   localparam int MARGIN_W   = 16;
   localparam int COUNT_W    = 4;
   localparam int CSR_DATA_W = 18;
   localparam int CSR_INDEX_W = 3;
   localparam int RSP_DATA_W = 8;

   // Register values after reset.
   localparam logic [LIMIT_W-1:0]  RST_NO_OBJECT_LIMIT = 18'd3000;
   localparam logic [LIMIT_W-1:0]  RST_ERROR_LIMIT     = 18'd100;
   localparam logic [MARGIN_W-1:0] RST_GRAY_LIMIT      = 16'd8;
   localparam logic [MARGIN_W-1:0] RST_COLOR_MARGIN    = 16'd15;
   localparam logic [MARGIN_W-1:0] RST_GREEN_MARGIN    = 16'd10;
   localparam logic [MARGIN_W-1:0] RST_RATIO_GATE      = 16'd20;
   localparam logic [COUNT_W-1:0]  RST_READINGS        = 4'd10;
   localparam logic [COUNT_W-1:0]  RST_MIN_VOTES       = 4'd3;

   typedef enum logic [2:0] {
      CLS_RED     = 3'd0,
      CLS_GREEN   = 3'd1,
      CLS_BLUE    = 3'd2,
      CLS_GRAY    = 3'd3,
      CLS_NOOBJ   = 3'd4,
      CLS_ERROR   = 3'd5,
      CLS_UNKNOWN = 3'd6
   } class_type;

   typedef enum logic [1:0] {
      FIN_RED     = 2'd0,
      FIN_GREEN   = 2'd1,
      FIN_BLUE    = 2'd2,
      FIN_UNKNOWN = 2'd3
   } final_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      REG_NO_OBJECT_LIMIT = 3'd0,
      REG_ERROR_LIMIT     = 3'd1,
      REG_GRAY_LIMIT      = 3'd2,
      REG_COLOR_MARGIN    = 3'd3,
      REG_GREEN_MARGIN    = 3'd4,
      REG_RATIO_GATE      = 3'd5,
      REG_READINGS        = 3'd6,
      REG_MIN_VOTES       = 3'd7
   } csr_index_type;

   typedef struct packed {
      logic [LIMIT_W-1:0]  no_object_limit;
      logic [LIMIT_W-1:0]  error_limit;
      logic [MARGIN_W-1:0] gray_limit;
      logic [MARGIN_W-1:0] color_margin;
      logic [MARGIN_W-1:0] green_margin;
      logic [MARGIN_W-1:0] ratio_gate;
      logic [COUNT_W-1:0]  readings_per_decision;
      logic [COUNT_W-1:0]  min_votes;
   } cfg_type;

   typedef struct packed {
      logic      last;
      final_type final_color;
   } decision_type;

endpackage

[hdl/rgb_color_classifier_vote.sv]
`timescale 1ns / 1ps

// RGB color classifier with majority vote.
//
// The req_ channel carries one reading per transfer: the red, green and blue
// low-pulse periods. Each reading is classified on its own (red, green, blue,
// white/gray, no object, sensor error or unknown) and every reading yields
// exactly one transfer on the rsp_ channel. Red, green and blue readings are
// counted as votes; the last reading of a voting round raises rsp_tlast and
// carries the winning color, after which the vote counters clear.
// The csr_ port writes the threshold registers with no wait.
//
// A reading is captured in the input register, then classified and voted in
// a single combinational pass into the result register.
// Throughput is one reading per clock unless the receiver stalls; the input and
// result registers let a new reading enter while the previous result waits.
// When the receiver holds rsp_tready low, the result register holds, then
// the input register fills, and only then does req_tready drop.
// Synchronous reset empties both registers, clears the vote counters and
// loads every threshold register with its default value.

module rgb_color_classifier_vote #(
   parameter int PERIOD_BITS = 16
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // red_period, green_period, blue_period from bit 0 up, zero padded
   input  logic [((3*PERIOD_BITS+7)/8)*8-1:0] req_tdata,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // reading_class, final_color from bit 0 up, zero padded
   output logic [rccv_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   // decision_valid: the last reading of a voting round
   output logic                               rsp_tlast,
   input  logic                               csr_we,
   input  logic [rccv_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [rccv_pkg::CSR_DATA_W-1:0]    csr_wdata
);
   import rccv_pkg::*;

   localparam int P = PERIOD_BITS;

   cfg_type          cfg_ff, cfg_in;
   logic             in_valid_ff, in_valid_in;
   logic             out_valid_ff, out_valid_in;
   logic [P-1:0]     red_ff, green_ff, blue_ff;
   class_type        class_ff, class_now;
   decision_type     decision_ff, decision_now;
   logic             advance;

   // Register writes.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index_type'(csr_index))
            REG_NO_OBJECT_LIMIT: cfg_in.no_object_limit = csr_wdata[LIMIT_W-1:0];
            REG_ERROR_LIMIT:     cfg_in.error_limit     = csr_wdata[LIMIT_W-1:0];
            REG_GRAY_LIMIT:      cfg_in.gray_limit      = csr_wdata[MARGIN_W-1:0];
            REG_COLOR_MARGIN:    cfg_in.color_margin    = csr_wdata[MARGIN_W-1:0];
            REG_GREEN_MARGIN:    cfg_in.green_margin    = csr_wdata[MARGIN_W-1:0];
            REG_RATIO_GATE:      cfg_in.ratio_gate      = csr_wdata[MARGIN_W-1:0];
            REG_READINGS:        cfg_in.readings_per_decision = csr_wdata[COUNT_W-1:0];
            REG_MIN_VOTES:       cfg_in.min_votes       = csr_wdata[COUNT_W-1:0];
            default:             cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.no_object_limit       <= RST_NO_OBJECT_LIMIT;
         cfg_ff.error_limit           <= RST_ERROR_LIMIT;
         cfg_ff.gray_limit            <= RST_GRAY_LIMIT;
         cfg_ff.color_margin          <= RST_COLOR_MARGIN;
         cfg_ff.green_margin          <= RST_GREEN_MARGIN;
         cfg_ff.ratio_gate            <= RST_RATIO_GATE;
         cfg_ff.readings_per_decision <= RST_READINGS;
         cfg_ff.min_votes             <= RST_MIN_VOTES;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // The input register moves forward whenever the result register is free
   // or is being emptied in the same cycle.
   always_comb begin
      advance      = in_valid_ff && (!out_valid_ff || rsp_tready);
      req_tready   = !in_valid_ff || advance;
      in_valid_in  = req_tready ? req_tvalid : in_valid_ff;
      out_valid_in = advance ? 1'b1 : (rsp_tready ? 1'b0 : out_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         red_ff   <= req_tdata[P-1:0];
         green_ff <= req_tdata[2*P-1:P];
         blue_ff  <= req_tdata[3*P-1:2*P];
      end
      if (advance) begin
         class_ff    <= class_now;
         decision_ff <= decision_now;
      end
   end

   rccv_classify #(
      .PERIOD_BITS(PERIOD_BITS)
   ) u_classify (
      .red_period   (red_ff),
      .green_period (green_ff),
      .blue_period  (blue_ff),
      .cfg          (cfg_ff),
      .reading_class(class_now)
   );

   rccv_vote u_vote (
      .clock                (clock),
      .reset                (reset),
      .step                 (advance),
      .reading_class        (class_now),
      .readings_per_decision(cfg_ff.readings_per_decision),
      .min_votes            (cfg_ff.min_votes),
      .decision             (decision_now)
   );

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tlast  = decision_ff.last;
   assign rsp_tdata  = {3'b000, decision_ff.final_color, class_ff};

   // A held reading keeps its periods until it moves into the result register.
   assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !advance |=> in_valid_ff && $stable(red_ff) &&
                                  $stable(green_ff) && $stable(blue_ff))
      else $error("held reading lost or changed");

   // Every reading that moves on shows up as a result in the next cycle.
   assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp_tvalid)
      else $error("result missing after a reading moved on");

   // A result that is not taken must not be overwritten.
   assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && !rsp_tready |-> !advance)
      else $error("waiting result overwritten");

endmodule

[hdl/rccv_classify.sv]
`timescale 1ns / 1ps

module rccv_classify #(
   parameter int PERIOD_BITS = 16
) (
   input  logic [PERIOD_BITS-1:0] red_period,
   input  logic [PERIOD_BITS-1:0] green_period,
   input  logic [PERIOD_BITS-1:0] blue_period,
   input  rccv_pkg::cfg_type      cfg,
   output rccv_pkg::class_type    reading_class
);
   import rccv_pkg::*;

   localparam int P       = PERIOD_BITS;
   localparam int SUM_W   = P + 2;
   localparam int LCMP_W  = (SUM_W > LIMIT_W) ? SUM_W : LIMIT_W;
   localparam int DCMP_W  = (P > MARGIN_W) ? P : MARGIN_W;
   localparam int MUL_W   = P + 4;
   localparam int GAP_W   = P + 5;
   localparam int ADV_W   = P + 7;

   logic [SUM_W-1:0] sum;
   logic [P-1:0]     r, g, b;
   logic [P-1:0]     rg, rb, gb, max_diff;
   logic [MUL_W-1:0] r10, g10, b10, r9, b9, r8, g8, b8;
   logic [ADV_W-1:0] rb_sum20, g42;
   logic [GAP_W-1:0] rg20, rb20, gb20, sum_gap;
   logic             g_min, g_strict, r_strict, b_strict;
   logic             green_a, green_b, red_ok, blue_ok, ratio_on;
   logic             is_noobj, is_error, is_gray;

   always_comb begin
      r = red_period;
      g = green_period;
      b = blue_period;
      sum = SUM_W'(r) + SUM_W'(g) + SUM_W'(b);
      rg = (r > g) ? r - g : g - r;
      rb = (r > b) ? r - b : b - r;
      gb = (g > b) ? g - b : b - g;
      max_diff = (rg > rb) ? rg : rb;
      if (gb > max_diff) begin
         max_diff = gb;
      end

      // Scaled periods for the 0.9 and 0.8 tests, cross-multiplied by ten.
      r10 = MUL_W'(r) * MUL_W'(10);
      g10 = MUL_W'(g) * MUL_W'(10);
      b10 = MUL_W'(b) * MUL_W'(10);
      r9  = MUL_W'(r) * MUL_W'(9);
      b9  = MUL_W'(b) * MUL_W'(9);
      r8  = MUL_W'(r) << 3;
      g8  = MUL_W'(g) << 3;
      b8  = MUL_W'(b) << 3;
      // Green advantage of 1.05: 20 * (r + b) against 42 * g.
      rb_sum20 = (ADV_W'(r) + ADV_W'(b)) * ADV_W'(20);
      g42      = ADV_W'(g) * ADV_W'(42);
      // Share-of-sum tests: each gap times 20 against the sum.
      rg20    = GAP_W'(rg) * GAP_W'(20);
      rb20    = GAP_W'(rb) * GAP_W'(20);
      gb20    = GAP_W'(gb) * GAP_W'(20);
      sum_gap = GAP_W'(sum);

      g_min    = (g <= r) && (g <= b);
      g_strict = (g < r) && (g < b);
      r_strict = (r < g) && (r < b);
      b_strict = (b < r) && (b < g);

      is_noobj = LCMP_W'(sum) > LCMP_W'(cfg.no_object_limit);
      is_error = LCMP_W'(sum) < LCMP_W'(cfg.error_limit);
      is_gray  = (DCMP_W'(rg) < DCMP_W'(cfg.gray_limit)) &&
                 (DCMP_W'(rb) < DCMP_W'(cfg.gray_limit)) &&
                 (DCMP_W'(gb) < DCMP_W'(cfg.gray_limit));

      green_a = g_min &&
                ((DCMP_W'(rg) > DCMP_W'(cfg.green_margin)) ||
                 (DCMP_W'(gb) > DCMP_W'(cfg.green_margin))) &&
                ((g10 < r9) || (g10 < b9));
      green_b = g_strict && (rb_sum20 > g42);
      red_ok  = r_strict &&
                (DCMP_W'(rg) > DCMP_W'(cfg.color_margin)) &&
                (DCMP_W'(rb) > DCMP_W'(cfg.color_margin)) &&
                (r10 < g8) && (r10 < b8);
      blue_ok = b_strict &&
                (DCMP_W'(rb) > DCMP_W'(cfg.color_margin)) &&
                (DCMP_W'(gb) > DCMP_W'(cfg.color_margin)) &&
                (b10 < r8) && (b10 < g8);
      ratio_on = DCMP_W'(max_diff) > DCMP_W'(cfg.ratio_gate);

      if (is_noobj) begin
         reading_class = CLS_NOOBJ;
      end else if (is_error) begin
         reading_class = CLS_ERROR;
      end else if (is_gray) begin
         reading_class = CLS_GRAY;
      end else if (green_a || green_b) begin
         reading_class = CLS_GREEN;
      end else if (red_ok) begin
         reading_class = CLS_RED;
      end else if (blue_ok) begin
         reading_class = CLS_BLUE;
      end else if (ratio_on && g_strict && (rg20 > sum_gap) && (gb20 > sum_gap)) begin
         reading_class = CLS_GREEN;
      end else if (ratio_on && r_strict && (rg20 > sum_gap) && (rb20 > sum_gap)) begin
         reading_class = CLS_RED;
      end else if (ratio_on && b_strict && (rb20 > sum_gap) && (gb20 > sum_gap)) begin
         reading_class = CLS_BLUE;
      end else begin
         reading_class = CLS_UNKNOWN;
      end
   end

endmodule

[hdl/rccv_vote.sv]
`timescale 1ns / 1ps

module rccv_vote (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           step,
   input  rccv_pkg::class_type            reading_class,
   input  logic [rccv_pkg::COUNT_W-1:0]   readings_per_decision,
   input  logic [rccv_pkg::COUNT_W-1:0]   min_votes,
   output rccv_pkg::decision_type         decision
);
   import rccv_pkg::*;

   localparam int TALLY_W = COUNT_W + 2;

   logic [COUNT_W-1:0] count_ff, count_in, count_inc;
   logic [COUNT_W-1:0] red_ff, red_in, red_inc;
   logic [COUNT_W-1:0] green_ff, green_in, green_inc;
   logic [COUNT_W-1:0] blue_ff, blue_in, blue_inc;
   logic [COUNT_W-1:0] round_len;
   logic               done;

   always_comb begin
      red_inc   = red_ff   + COUNT_W'(reading_class == CLS_RED);
      green_inc = green_ff + COUNT_W'(reading_class == CLS_GREEN);
      blue_inc  = blue_ff  + COUNT_W'(reading_class == CLS_BLUE);
      count_inc = count_ff + COUNT_W'(1);
      // A round length of zero behaves as one reading.
      round_len = (readings_per_decision == '0) ? COUNT_W'(1) : readings_per_decision;
      done      = count_inc >= round_len;

      decision.last        = done;
      decision.final_color = FIN_UNKNOWN;
      if (done) begin
         if (red_inc >= green_inc && red_inc >= blue_inc && red_inc >= min_votes) begin
            decision.final_color = FIN_RED;
         end else if (green_inc >= red_inc && green_inc >= blue_inc &&
                      green_inc >= min_votes) begin
            decision.final_color = FIN_GREEN;
         end else if (blue_inc >= red_inc && blue_inc >= green_inc &&
                      blue_inc >= min_votes) begin
            decision.final_color = FIN_BLUE;
         end
      end

      count_in = count_ff;
      red_in   = red_ff;
      green_in = green_ff;
      blue_in  = blue_ff;
      if (step) begin
         count_in = done ? '0 : count_inc;
         red_in   = done ? '0 : red_inc;
         green_in = done ? '0 : green_inc;
         blue_in  = done ? '0 : blue_inc;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         red_ff   <= '0;
         green_ff <= '0;
         blue_ff  <= '0;
      end else begin
         count_ff <= count_in;
         red_ff   <= red_in;
         green_ff <= green_in;
         blue_ff  <= blue_in;
      end
   end

   // Votes are only cast together with a reading, so they never outnumber it.
   assert property (@(posedge clock) disable iff (reset)
      (TALLY_W'(red_ff) + TALLY_W'(green_ff) + TALLY_W'(blue_ff)) <= TALLY_W'(count_ff))
      else $error("vote total exceeds the reading count");

   assert property (@(posedge clock) disable iff (reset)
      step && decision.last |=> (count_ff == '0) && (red_ff == '0) &&
                                (green_ff == '0) && (blue_ff == '0))
      else $error("counters not cleared after a decision");

   assert property (@(posedge clock) disable iff (reset)
      !step |=> $stable(count_ff) && $stable(red_ff) && $stable(green_ff) && $stable(blue_ff))
      else $error("vote state changed without a reading");

   assert property (@(posedge clock)
      reset |=> (count_ff == '0) && (red_ff == '0))
      else $error("vote state not cleared by reset");

endmodule

[tb/sv/tb_rgb_color_classifier_vote.sv]
`timescale 1ns / 1ps

// The testbench drives readings into the classifier and predicts each result
// alongside it. The driver and the monitor are clocked processes. The driver
// takes readings from a queue that the main sequence fills, and it predicts
// each reading at the edge where its transfer happens. The monitor checks
// every result transfer against the oldest prediction.
module tb_rgb_color_classifier_vote;
   import rccv_pkg::*;

   localparam int PERIOD_BITS      = 16;
   localparam int PERIOD_MAX       = (1 << PERIOD_BITS) - 1;
   localparam int REQ_W            = ((3 * PERIOD_BITS + 7) / 8) * 8;
   localparam int LONG_HOLD_CYCLES = 80;
   localparam int CYCLE_LIMIT      = 100000;

   // One reading waiting to be offered. The gap is the number of idle cycles
   // before it is offered. When drain_first is set, the driver also holds the
   // reading back until every predicted result has come out.
   typedef struct {
      logic [PERIOD_BITS-1:0] red;
      logic [PERIOD_BITS-1:0] green;
      logic [PERIOD_BITS-1:0] blue;
      int unsigned            gap;
      bit                     drain_first;
   } reading_item_type;

   // What one reading must produce on the result channel.
   typedef struct {
      class_type cls;
      logic      last;
      final_type fin;
   } vote_result_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_W-1:0]       req_tdata = '0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0]  rsp_tdata;
   logic                   rsp_tlast;
   logic                   csr_we = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata = '0;

   // This is the predictor's own copy of the registers and the voting state.
   cfg_type    cfg_mirror;
   logic [3:0] readings_in_round = '0;
   logic [3:0] votes_red = '0;
   logic [3:0] votes_green = '0;
   logic [3:0] votes_blue = '0;

   reading_item_type pending_readings[$];
   vote_result_type  predicted_outcomes[$];

   int unsigned mismatch_count = 0;
   int unsigned cycle_count = 0;
   int unsigned gap_left = 0;
   bit          gap_loaded = 1'b0;
   int unsigned stall_left = 0;
   int unsigned rsp_stall_max = 3;
   int unsigned hold_left = 0;
   logic        hold_request = 1'b0;

   rgb_color_classifier_vote #(
      .PERIOD_BITS(PERIOD_BITS)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // This function classifies one reading with the current register values.
   // All scaled tests are exact cross-multiplications. The products stay far
   // inside 64 bits, so nothing wraps.
   function automatic class_type classify_reading(input logic [PERIOD_BITS-1:0] red_in,
                                                  input logic [PERIOD_BITS-1:0] green_in,
                                                  input logic [PERIOD_BITS-1:0] blue_in);
      logic [63:0] r, g, b, sum, d_rg, d_rb, d_gb, lowest, widest;
      r = red_in;
      g = green_in;
      b = blue_in;
      sum = r + g + b;
      d_rg = (r > g) ? r - g : g - r;
      d_rb = (r > b) ? r - b : b - r;
      d_gb = (g > b) ? g - b : b - g;

      if (sum > cfg_mirror.no_object_limit) return CLS_NOOBJ;
      if (sum < cfg_mirror.error_limit) return CLS_ERROR;
      if (d_rg < cfg_mirror.gray_limit && d_rb < cfg_mirror.gray_limit &&
          d_gb < cfg_mirror.gray_limit)
         return CLS_GRAY;

      // Green gets the first chance whenever it is at the minimum, even when
      // it ties with another color.
      lowest = (r < g) ? r : g;
      if (b < lowest) lowest = b;
      if (g == lowest) begin
         if ((d_rg > cfg_mirror.green_margin || d_gb > cfg_mirror.green_margin) &&
             (g * 10 < r * 9 || g * 10 < b * 9))
            return CLS_GREEN;
         if (g < r && g < b && (r + b) * 20 > g * 42)
            return CLS_GREEN;
      end
      if (r < g && r < b && d_rg > cfg_mirror.color_margin &&
          d_rb > cfg_mirror.color_margin && r * 10 < g * 8 && r * 10 < b * 8)
         return CLS_RED;
      if (b < r && b < g && d_rb > cfg_mirror.color_margin &&
          d_gb > cfg_mirror.color_margin && b * 10 < r * 8 && b * 10 < g * 8)
         return CLS_BLUE;

      // The share-of-sum fallback applies only when the spread is wide enough.
      widest = (d_rg > d_rb) ? d_rg : d_rb;
      if (d_gb > widest) widest = d_gb;
      if (widest > cfg_mirror.ratio_gate) begin
         if (g < r && g < b) begin
            if ((r - g) * 20 > sum && (b - g) * 20 > sum) return CLS_GREEN;
         end else if (r < g && r < b) begin
            if ((g - r) * 20 > sum && (b - r) * 20 > sum) return CLS_RED;
         end else if (b < r && b < g) begin
            if ((r - b) * 20 > sum && (g - b) * 20 > sum) return CLS_BLUE;
         end
      end
      return CLS_UNKNOWN;
   endfunction

   // This task counts one reading into the current voting round and gives
   // back the result that the reading must produce. A round length of zero
   // acts as one. A round also ends at once when its length was lowered
   // below the count already reached.
   task automatic tally_reading(input logic [PERIOD_BITS-1:0] red_in,
                                input logic [PERIOD_BITS-1:0] green_in,
                                input logic [PERIOD_BITS-1:0] blue_in,
                                output vote_result_type outcome);
      logic [3:0] round_len;
      outcome.cls = classify_reading(red_in, green_in, blue_in);
      outcome.last = 1'b0;
      outcome.fin = FIN_UNKNOWN;
      case (outcome.cls)
         CLS_RED:   votes_red = votes_red + 4'd1;
         CLS_GREEN: votes_green = votes_green + 4'd1;
         CLS_BLUE:  votes_blue = votes_blue + 4'd1;
         default: ;
      endcase
      readings_in_round = readings_in_round + 4'd1;
      round_len = (cfg_mirror.readings_per_decision == '0) ? 4'd1 :
                  cfg_mirror.readings_per_decision;
      if (readings_in_round >= round_len) begin
         outcome.last = 1'b1;
         if (votes_red >= votes_green && votes_red >= votes_blue &&
             votes_red >= cfg_mirror.min_votes)
            outcome.fin = FIN_RED;
         else if (votes_green >= votes_red && votes_green >= votes_blue &&
                  votes_green >= cfg_mirror.min_votes)
            outcome.fin = FIN_GREEN;
         else if (votes_blue >= votes_red && votes_blue >= votes_green &&
                  votes_blue >= cfg_mirror.min_votes)
            outcome.fin = FIN_BLUE;
         readings_in_round = '0;
         votes_red = '0;
         votes_green = '0;
         votes_blue = '0;
      end
   endtask

   task automatic report_mismatch(input string what);
      if (mismatch_count < 150)
         $display("[%0t] mismatch: %s", $time, what);
      mismatch_count++;
   endtask

   // Driver. Each reading is predicted at the edge of its transfer, using the
   // data that was on the bus. The next reading then goes out at once, unless
   // its gap or a drain request holds it back.
   always @(posedge clock) begin
      vote_result_type  outcome;
      reading_item_type next_item;
      logic             offer;
      logic [REQ_W-1:0] next_data;
      offer = req_tvalid;
      next_data = req_tdata;
      if (reset) begin
         offer = 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            tally_reading(req_tdata[0 +: PERIOD_BITS], req_tdata[PERIOD_BITS +: PERIOD_BITS],
                          req_tdata[2*PERIOD_BITS +: PERIOD_BITS], outcome);
            predicted_outcomes.push_back(outcome);
            offer = 1'b0;
         end
         if (!offer && pending_readings.size() != 0) begin
            if (!gap_loaded) begin
               gap_left = pending_readings[0].gap;
               gap_loaded = 1'b1;
            end
            if (gap_left != 0) begin
               gap_left--;
            end else if (!pending_readings[0].drain_first || predicted_outcomes.size() == 0) begin
               next_item = pending_readings.pop_front();
               next_data = {next_item.blue, next_item.green, next_item.red};
               offer = 1'b1;
               gap_loaded = 1'b0;
            end
         end
      end
      req_tvalid <= offer;
      req_tdata <= next_data;
   end

   // Monitor. Each result transfer is compared field by field with the oldest
   // prediction. After each transfer the monitor draws a random stall, bounded
   // by rsp_stall_max. A long hold, when one is running, overrides the stall.
   always @(posedge clock) begin
      vote_result_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
         stall_left = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (predicted_outcomes.size() == 0) begin
               report_mismatch($sformatf("result with nothing predicted, data %h last %b",
                                         rsp_tdata, rsp_tlast));
            end else begin
               want = predicted_outcomes.pop_front();
               if (rsp_tdata[2:0] !== want.cls)
                  report_mismatch($sformatf("reading_class %0d, predicted %0d",
                                            rsp_tdata[2:0], want.cls));
               if (rsp_tlast !== want.last)
                  report_mismatch($sformatf("decision_valid %b, predicted %b",
                                            rsp_tlast, want.last));
               if (rsp_tdata[4:3] !== want.fin)
                  report_mismatch($sformatf("final_color %0d, predicted %0d",
                                            rsp_tdata[4:3], want.fin));
            end
            stall_left = $urandom_range(0, rsp_stall_max);
         end
         if (hold_left != 0) begin
            rsp_tready <= 1'b0;
         end else if (stall_left != 0) begin
            stall_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // The long receiver hold has its own counter. The main sequence starts it
   // with a one-cycle request while the driver keeps offering readings
   // back to back.
   always @(posedge clock) begin
      if (reset) begin
         hold_left <= 0;
      end else if (hold_request) begin
         hold_left <= LONG_HOLD_CYCLES;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("tb_rgb_color_classifier_vote failed");
         $finish;
      end
   end

   // This task writes one register and updates the mirror to match. It is
   // called only while the block is idle, so no reading can see the mirror
   // change ahead of the hardware.
   task automatic write_register(input csr_index_type idx, input logic [CSR_DATA_W-1:0] value);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      case (idx)
         REG_NO_OBJECT_LIMIT: cfg_mirror.no_object_limit = value[LIMIT_W-1:0];
         REG_ERROR_LIMIT:     cfg_mirror.error_limit = value[LIMIT_W-1:0];
         REG_GRAY_LIMIT:      cfg_mirror.gray_limit = value[MARGIN_W-1:0];
         REG_COLOR_MARGIN:    cfg_mirror.color_margin = value[MARGIN_W-1:0];
         REG_GREEN_MARGIN:    cfg_mirror.green_margin = value[MARGIN_W-1:0];
         REG_RATIO_GATE:      cfg_mirror.ratio_gate = value[MARGIN_W-1:0];
         REG_READINGS:        cfg_mirror.readings_per_decision = value[COUNT_W-1:0];
         REG_MIN_VOTES:       cfg_mirror.min_votes = value[COUNT_W-1:0];
         default: ;
      endcase
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic load_config(input cfg_type c);
      write_register(REG_NO_OBJECT_LIMIT, c.no_object_limit);
      write_register(REG_ERROR_LIMIT, c.error_limit);
      write_register(REG_GRAY_LIMIT, c.gray_limit);
      write_register(REG_COLOR_MARGIN, c.color_margin);
      write_register(REG_GREEN_MARGIN, c.green_margin);
      write_register(REG_RATIO_GATE, c.ratio_gate);
      write_register(REG_READINGS, c.readings_per_decision);
      write_register(REG_MIN_VOTES, c.min_votes);
      @(negedge clock);
   endtask

   task automatic load_random_config();
      cfg_type c;
      c.no_object_limit = LIMIT_W'($urandom_range(600, 4000));
      c.error_limit = LIMIT_W'($urandom_range(0, 400));
      c.gray_limit = MARGIN_W'($urandom_range(0, 20));
      c.color_margin = MARGIN_W'($urandom_range(0, 40));
      c.green_margin = MARGIN_W'($urandom_range(0, 30));
      c.ratio_gate = MARGIN_W'($urandom_range(0, 40));
      c.readings_per_decision = COUNT_W'($urandom_range(0, 15));
      c.min_votes = COUNT_W'($urandom_range(0, 6));
      load_config(c);
   endtask

   // The block is idle once the driver has nothing left to offer and every
   // predicted result has been received.
   task automatic wait_until_idle();
      @(negedge clock);
      while (pending_readings.size() != 0 || req_tvalid || predicted_outcomes.size() != 0)
         @(negedge clock);
   endtask

   function automatic void add_reading(input logic [PERIOD_BITS-1:0] r,
                                       input logic [PERIOD_BITS-1:0] g,
                                       input logic [PERIOD_BITS-1:0] b);
      reading_item_type item;
      item.red = r;
      item.green = g;
      item.blue = b;
      item.gap = $urandom_range(0, 3);
      item.drain_first = 1'b0;
      pending_readings.push_back(item);
   endfunction

   // Most random readings look like a real object. The three periods sit
   // close to each other, and often one of them is pulled down so that one
   // color stands out. The rest are sums placed right at the presence limits,
   // plus fully random words that reach every bit.
   function automatic reading_item_type make_random_reading(input int unsigned gap_max);
      reading_item_type item;
      int unsigned chan [3];
      int unsigned pick, base, spread, target;
      int          k;
      pick = $urandom_range(0, 9);
      if (pick < 2) begin
         for (int j = 0; j < 3; j++) chan[j] = $urandom_range(0, PERIOD_MAX);
      end else if (pick < 4) begin
         target = ($urandom_range(0, 1) != 0) ? 32'(cfg_mirror.no_object_limit) :
                  32'(cfg_mirror.error_limit);
         for (int j = 0; j < 3; j++) begin
            chan[j] = target / 3 + $urandom_range(0, 4);
            chan[j] = (chan[j] >= 2) ? chan[j] - 2 : 0;
         end
      end else begin
         base = $urandom_range(20, 1000);
         case ($urandom_range(0, 3))
            0: spread = 6;
            1: spread = 25;
            2: spread = 120;
            default: spread = base;
         endcase
         for (int j = 0; j < 3; j++) chan[j] = base + $urandom_range(0, spread);
         if ($urandom_range(0, 2) != 0) begin
            k = $urandom_range(0, 2);
            chan[k] = chan[k] * $urandom_range(5, 10) / 10;
         end
      end
      for (int j = 0; j < 3; j++)
         if (chan[j] > PERIOD_MAX) chan[j] = PERIOD_MAX;
      item.red = PERIOD_BITS'(chan[0]);
      item.green = PERIOD_BITS'(chan[1]);
      item.blue = PERIOD_BITS'(chan[2]);
      item.gap = $urandom_range(0, gap_max);
      item.drain_first = 1'b0;
      return item;
   endfunction

   // Every fiftieth random reading waits for the pipeline to drain first,
   // so the block also starts from empty partway through a phase.
   task automatic queue_random(input int unsigned count, input int unsigned gap_max);
      reading_item_type item;
      for (int unsigned i = 0; i < count; i++) begin
         item = make_random_reading(gap_max);
         item.drain_first = (i % 50 == 25);
         pending_readings.push_back(item);
      end
   endtask

   initial begin
      cfg_type phase_cfg;
      cfg_mirror = {RST_NO_OBJECT_LIMIT, RST_ERROR_LIMIT, RST_GRAY_LIMIT, RST_COLOR_MARGIN,
                    RST_GREEN_MARGIN, RST_RATIO_GATE, RST_READINGS, RST_MIN_VOTES};
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // These readings run with the register values from reset. They hit the
      // edges of both sum limits, a gray reading, all three color tests, the
      // second green test, a green that ties for the minimum, red and blue
      // by the share-of-sum fallback, and unknown readings. The fifteen
      // readings leave the second round five readings in.
      add_reading(0, 0, 0);
      add_reading(PERIOD_MAX, PERIOD_MAX, PERIOD_MAX);
      add_reading(1000, 1000, 1000);
      add_reading(1001, 1000, 1000);
      add_reading(33, 33, 33);
      add_reading(34, 33, 33);
      add_reading(200, 100, 200);
      add_reading(100, 200, 200);
      add_reading(200, 200, 100);
      add_reading(109, 100, 109);
      add_reading(100, 121, 121);
      add_reading(121, 121, 100);
      add_reading(100, 120, 120);
      add_reading(100, 100, 200);
      add_reading(100, 200, 100);
      wait_until_idle();

      // Shortening the round below the count already reached must end the
      // round on the very next reading.
      write_register(REG_READINGS, 3);
      @(negedge clock);
      add_reading(100, 200, 200);
      wait_until_idle();

      // A round length of zero acts as one. With no minimum vote count, a
      // round that holds no color vote still decides red.
      write_register(REG_READINGS, 0);
      write_register(REG_MIN_VOTES, 0);
      @(negedge clock);
      add_reading(1000, 1000, 1000);
      add_reading(200, 200, 100);
      add_reading(200, 100, 200);
      wait_until_idle();

      // Go back to the reset values. While the receiver holds off for a
      // long stretch, the driver keeps offering readings back to back. The
      // block fills up and drops req_tready.
      phase_cfg = {RST_NO_OBJECT_LIMIT, RST_ERROR_LIMIT, RST_GRAY_LIMIT, RST_COLOR_MARGIN,
                   RST_GREEN_MARGIN, RST_RATIO_GATE, RST_READINGS, RST_MIN_VOTES};
      load_config(phase_cfg);
      rsp_stall_max = 0;
      queue_random(60, 0);
      @(posedge clock);
      hold_request <= 1'b1;
      @(posedge clock);
      hold_request <= 1'b0;
      wait_until_idle();
      rsp_stall_max = 3;
      queue_random(120, 3);
      wait_until_idle();

      // This phase uses the widest presence window and zero for every margin,
      // with the longest rounds and the highest vote minimum.
      phase_cfg.no_object_limit = 196605;
      phase_cfg.error_limit = 0;
      phase_cfg.gray_limit = 0;
      phase_cfg.color_margin = 0;
      phase_cfg.green_margin = 0;
      phase_cfg.ratio_gate = 0;
      phase_cfg.readings_per_decision = 15;
      phase_cfg.min_votes = 15;
      load_config(phase_cfg);
      queue_random(160, 3);
      wait_until_idle();

      // Every margin is at its maximum here, and each reading forms a round
      // on its own.
      phase_cfg.gray_limit = 16'hFFFF;
      phase_cfg.color_margin = 16'hFFFF;
      phase_cfg.green_margin = 16'hFFFF;
      phase_cfg.ratio_gate = 16'hFFFF;
      phase_cfg.readings_per_decision = 1;
      phase_cfg.min_votes = 0;
      load_config(phase_cfg);
      queue_random(40, 3);
      wait_until_idle();

      repeat (2) begin
         load_random_config();
         queue_random(150, 3);
         wait_until_idle();
      end

      // The pipeline is two registers deep. A few more cycles give any extra
      // result time to show up at the monitor.
      repeat (4) @(posedge clock);
      if (mismatch_count == 0)
         $display("tb_rgb_color_classifier_vote passed");
      else
         $display("tb_rgb_color_classifier_vote failed");
      $finish;
   end

endmodule

[rgb_color_classifier_vote.f]
hdl/rccv_pkg.sv
hdl/rccv_classify.sv
hdl/rccv_vote.sv
hdl/rgb_color_classifier_vote.sv
tb/sv/tb_rgb_color_classifier_vote.sv
